// ===== design/sob3x3_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the 3x3 Sobel gradient filter.
// No dependencies; imported by every module of the block.
package sob3x3_pkg;

  localparam int PIX_W  = 8;
  localparam int GRAD_W = 16;
  localparam int COL_W  = 10;
  localparam int ROW_W  = 12;
  localparam int LW_W   = 11;
  localparam int GSUM_W = 12;   // one gradient before sign extension: -1020..1020

  localparam logic [LW_W-1:0]  LW_RESET = 11'd640;
  localparam logic [ROW_W-1:0] ROW_SAT  = 12'd4095;

  // Column of the window leaving the line-store stage
  typedef struct packed {
    logic              valid;
    logic              emit;
    logic [PIX_W-1:0]  top;
    logic [PIX_W-1:0]  mid;
    logic [PIX_W-1:0]  px;
    logic [COL_W-1:0]  ccol;
    logic [ROW_W-1:0]  crow;
  } col_t;

  typedef struct packed {
    logic [ROW_W-1:0]         center_row;
    logic [COL_W-1:0]         center_col;
    logic signed [GRAD_W-1:0] grad_y;
    logic signed [GRAD_W-1:0] grad_x;
  } res_t;

endpackage

// ===== design/sobel_3x3_gradient.sv =====
`timescale 1ns / 1ps
// Sobel 3x3 gradient filter, top level: config register, handshakes, submodules.
// Depends on sob3x3_pkg, sob3x3_front, sob3x3_grad, sob3x3_resq.
//
// Takes one 8-bit pixel per clock in raster order; tuser marks the first pixel of
// a frame. For every pixel that completes a 3x3 neighborhood inside the image,
// one output beat carries the X and Y gradients and the window center's column and
// row; border pixels give no beat. A result enters the output queue in the cycle after
// its pixel is accepted and is then offered on the output port. The rate is one pixel
// per cycle, set by the two line stores, each doing one read and one write per cycle;
// s_axis_tready drops only when the four-entry result queue plus the beat in flight
// would fill it. line_width is clamped to 3..MAX_WIDTH and must be written only
// while the block is idle.
module sobel_3x3_gradient
  import sob3x3_pkg::*;
#(
  parameter int MAX_WIDTH = 1024
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_we_i,
  input  logic [LW_W-1:0] cfg_wdata_i,     // line_width
  input  logic            s_axis_tvalid,
  output logic            s_axis_tready,
  input  logic [7:0]      s_axis_tdata,    // [7:0] pixel
  input  logic            s_axis_tuser,    // [0] frame_start
  output logic            m_axis_tvalid,
  input  logic            m_axis_tready,
  output logic [55:0]     m_axis_tdata     // [15:0] grad_x, [31:16] grad_y,
                                           // [41:32] center_col, [53:42] center_row
);

  logic [LW_W-1:0] line_width_q;
  logic            in_fire;
  col_t            col;
  logic            res_valid;
  res_t            res, q_data;
  logic [2:0]      q_count;
  logic [2:0]      pending;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_width_q <= LW_RESET;
    end else if (cfg_we_i) begin
      line_width_q <= cfg_wdata_i;
    end
  end

  assign pending       = q_count + 3'(col.valid);
  assign s_axis_tready = (pending <= 3'd3);
  assign in_fire       = s_axis_tvalid && s_axis_tready;

  sob3x3_front #(
    .MAX_WIDTH(MAX_WIDTH)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_fire_i     (in_fire),
    .pixel_i       (s_axis_tdata),
    .frame_start_i (s_axis_tuser),
    .line_width_i  (line_width_q),
    .col_o         (col)
  );

  sob3x3_grad u_grad (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .col_i       (col),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  sob3x3_resq u_resq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (res_valid),
    .push_data_i (res),
    .pop_i       (m_axis_tready),
    .valid_o     (m_axis_tvalid),
    .data_o      (q_data),
    .count_o     (q_count)
  );

  assign m_axis_tdata = {2'b00, q_data.center_row, q_data.center_col,
                         q_data.grad_y, q_data.grad_x};

`ifndef SYNTH
  a_ready_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready |-> (q_count + 3'(col.valid) < 3'd4))
    else $error("input accepted without room for its result");
`endif

endmodule

// ===== design/sob3x3_front.sv =====
`timescale 1ns / 1ps
// Column/row counters and the two line stores with registered reads.
// Depends on sob3x3_pkg. Forwards the previous beat's writes on an address match.
module sob3x3_front
  import sob3x3_pkg::*;
#(
  parameter int MAX_WIDTH = 1024
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_fire_i,
  input  logic [PIX_W-1:0] pixel_i,
  input  logic             frame_start_i,
  input  logic [LW_W-1:0]  line_width_i,
  output col_t             col_o
);

  localparam int CW   = $clog2(MAX_WIDTH);
  localparam int WW   = $clog2(MAX_WIDTH + 1);
  localparam int CMPW = (WW > LW_W) ? WW : LW_W;

  logic [PIX_W-1:0] mem_up  [MAX_WIDTH];
  logic [PIX_W-1:0] mem_mid [MAX_WIDTH];

  logic [CW-1:0]    col_q, col_d;
  logic [ROW_W-1:0] row_q, row_d;
  logic             s1_valid_q;
  logic             s1_emit_q;
  logic [PIX_W-1:0] s1_px_q;
  logic [CW-1:0]    s1_c_q;
  logic [COL_W-1:0] s1_ccol_q;
  logic [ROW_W-1:0] s1_crow_q;
  logic             fwd_q, fwd_d;
  logic [PIX_W-1:0] fwd_top_q, fwd_mid_q;
  logic [PIX_W-1:0] rd_up_q, rd_mid_q;

  logic [CMPW-1:0]  lw, w, cn;
  logic [CW-1:0]    c0;
  logic [ROW_W-1:0] r0, row_inc;
  logic [PIX_W-1:0] eff_top, eff_mid;

  assign eff_top = fwd_q ? fwd_top_q : rd_up_q;
  assign eff_mid = fwd_q ? fwd_mid_q : rd_mid_q;

  always_comb begin
    lw = CMPW'(line_width_i);
    if (lw < CMPW'(3)) begin
      w = CMPW'(3);
    end else if (lw > CMPW'(MAX_WIDTH)) begin
      w = CMPW'(MAX_WIDTH);
    end else begin
      w = lw;
    end
  end

  always_comb begin
    row_inc = (row_q == ROW_SAT) ? row_q : row_q + ROW_W'(1);
    if (frame_start_i) begin
      c0 = '0;
      r0 = '0;
    end else if (CMPW'(col_q) >= w) begin
      c0 = '0;  // width lowered mid-row
      r0 = row_inc;
    end else begin
      c0 = col_q;
      r0 = row_q;
    end
    cn = CMPW'(c0) + CMPW'(1);
    if (cn >= w) begin
      col_d = '0;
      row_d = (r0 == ROW_SAT) ? r0 : r0 + ROW_W'(1);
    end else begin
      col_d = cn[CW-1:0];
      row_d = r0;
    end
    // back-to-back beats at one column: previous beat's writes are not yet visible
    fwd_d = s1_valid_q && (s1_c_q == c0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q      <= '0;
      row_q      <= '0;
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= in_fire_i;
      if (in_fire_i) begin
        col_q <= col_d;
        row_q <= row_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire_i) begin
      s1_px_q   <= pixel_i;
      s1_c_q    <= c0;
      s1_emit_q <= (c0 >= CW'(2)) && (r0 >= ROW_W'(2));
      s1_ccol_q <= COL_W'(c0 - CW'(1));
      s1_crow_q <= r0 - ROW_W'(1);
      fwd_q     <= fwd_d;
      fwd_top_q <= eff_mid;
      fwd_mid_q <= s1_px_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire_i) begin
      rd_up_q <= mem_up[c0];
    end
    if (s1_valid_q) begin
      mem_up[s1_c_q] <= eff_mid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire_i) begin
      rd_mid_q <= mem_mid[c0];
    end
    if (s1_valid_q) begin
      mem_mid[s1_c_q] <= s1_px_q;
    end
  end

  always_comb begin
    col_o.valid = s1_valid_q;
    col_o.emit  = s1_emit_q;
    col_o.top   = eff_top;
    col_o.mid   = eff_mid;
    col_o.px    = s1_px_q;
    col_o.ccol  = s1_ccol_q;
    col_o.crow  = s1_crow_q;
  end

`ifndef SYNTH
  a_fs_origin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire_i && frame_start_i) |=> (s1_c_q == '0 && !s1_emit_q))
    else $error("frame start did not restart at column 0");
  a_col_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q |-> (CMPW'(s1_c_q) < CMPW'(MAX_WIDTH)))
    else $error("line store address out of range");
`endif

endmodule

// ===== design/sob3x3_grad.sv =====
`timescale 1ns / 1ps
// 3x3 window shift and the Sobel X/Y sums.
// Depends on sob3x3_pkg; fed by sob3x3_front.
module sob3x3_grad
  import sob3x3_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  col_t col_i,
  output logic res_valid_o,
  output res_t res_o
);

  // [0..2] column c-2, [3..5] column c-1; top, middle, bottom
  logic [PIX_W-1:0] win_q [6];

  logic [GSUM_W-2:0]      sx_r, sx_l, sy_b, sy_t;
  logic signed [GSUM_W-1:0] gx, gy;

  always_comb begin
    sx_r = (GSUM_W-1)'(col_i.top) + ((GSUM_W-1)'(col_i.mid) << 1) + (GSUM_W-1)'(col_i.px);
    sx_l = (GSUM_W-1)'(win_q[0]) + ((GSUM_W-1)'(win_q[1]) << 1) + (GSUM_W-1)'(win_q[2]);
    sy_b = (GSUM_W-1)'(win_q[2]) + ((GSUM_W-1)'(win_q[5]) << 1) + (GSUM_W-1)'(col_i.px);
    sy_t = (GSUM_W-1)'(win_q[0]) + ((GSUM_W-1)'(win_q[3]) << 1) + (GSUM_W-1)'(col_i.top);
    gx = $signed({1'b0, sx_r}) - $signed({1'b0, sx_l});
    gy = $signed({1'b0, sy_b}) - $signed({1'b0, sy_t});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 6; i++) begin
        win_q[i] <= '0;
      end
    end else if (col_i.valid) begin
      win_q[0] <= win_q[3];
      win_q[1] <= win_q[4];
      win_q[2] <= win_q[5];
      win_q[3] <= col_i.top;
      win_q[4] <= col_i.mid;
      win_q[5] <= col_i.px;
    end
  end

  // sums stay within +-1020, so the 16-bit clamp reduces to sign extension
  assign res_valid_o      = col_i.valid && col_i.emit;
  assign res_o.grad_x     = {{(GRAD_W-GSUM_W){gx[GSUM_W-1]}}, gx};
  assign res_o.grad_y     = {{(GRAD_W-GSUM_W){gy[GSUM_W-1]}}, gy};
  assign res_o.center_col = col_i.ccol;
  assign res_o.center_row = col_i.crow;

endmodule

// ===== design/sob3x3_resq.sv =====
`timescale 1ns / 1ps
// Four-entry result queue between the gradient logic and the output port.
// Depends on sob3x3_pkg.
module sob3x3_resq
  import sob3x3_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  input  res_t       push_data_i,
  input  logic       pop_i,
  output logic       valid_o,
  output res_t       data_o,
  output logic [2:0] count_o
);

  localparam int DEPTH = 4;

  res_t       ent_q [DEPTH];
  logic [1:0] wr_q, rd_q;
  logic [2:0] cnt_q;
  logic       pop;

  assign pop     = pop_i && (cnt_q != '0);
  assign valid_o = (cnt_q != '0);
  assign data_o  = ent_q[rd_q];
  assign count_o = cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= wr_q + 2'd1;
      end
      if (pop) begin
        rd_q <= rd_q + 2'd1;
      end
      case ({push_i, pop})
        2'b10:   cnt_q <= cnt_q + 3'd1;
        2'b01:   cnt_q <= cnt_q - 3'd1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      ent_q[wr_q] <= push_data_i;
    end
  end

`ifndef SYNTH
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == 3'(DEPTH)) |-> (!push_i || pop))
    else $error("result queue overflow");
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= 3'(DEPTH))
    else $error("result queue count out of range");
`endif

endmodule
